### rtl/core/lssc_pkg.sv
// Package for the LED session safety controller: operation and register codes,
// refusal and shutdown codes, session limits and the result word type.
// No dependencies.
package lssc_pkg;

	// operation field codes
	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_START   = 3'd1,
		OP_STOP    = 3'd2,
		OP_BATTERY = 3'd3,
		OP_TEMP    = 3'd4
	} op_t;

	// treatment modes
	typedef enum logic [2:0] {
		MODE_RED   = 3'd1,
		MODE_NIR   = 3'd2,
		MODE_BOTH  = 3'd3,
		MODE_ALT   = 3'd4
	} mode_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_MODE       = 3'd0,
		REG_SESSION    = 3'd1,
		REG_ALTERNATE  = 3'd2,
		REG_BAT_CUTOFF = 3'd3,
		REG_BAT_LOW    = 3'd4,
		REG_BAT_OVER   = 3'd5,
		REG_TEMP_WARN  = 3'd6,
		REG_TEMP_CUT   = 3'd7
	} reg_idx_t;

	// start refusal reasons
	typedef enum logic [2:0] {
		REFUSE_NONE  = 3'd0,
		REFUSE_LOW   = 3'd1,
		REFUSE_HIGH  = 3'd2,
		REFUSE_HOT   = 3'd3,
		REFUSE_DAILY = 3'd4,
		REFUSE_GAP   = 3'd5
	} refusal_t;

	// emergency shutdown causes
	typedef enum logic [1:0] {
		CAUSE_NONE    = 2'd0,
		CAUSE_OVER    = 2'd1,
		CAUSE_UNDER   = 2'd2,
		CAUSE_THERMAL = 2'd3
	} cause_t;

	// session limits
	localparam int unsigned MAX_DAILY           = 3;
	localparam int unsigned MIN_GAP_MINUTES     = 60;
	localparam int unsigned MAX_SESSION_SECONDS = 1800;
	localparam int unsigned DAY_SECONDS         = 86400;
	localparam int unsigned GAP_SECONDS         = MIN_GAP_MINUTES * 60;

	localparam logic [7:0] DRIVE_FULL = 8'd255;
	localparam logic [7:0] DRIVE_HALF = 8'd128;
	localparam logic signed [8:0] TEMP_HYST = 9'sd5;

	// one result word
	typedef struct packed {
		logic [7:0]  red_duty;
		logic [7:0]  nir_duty;
		logic        session_on;
		logic [15:0] elapsed_seconds;
		logic [2:0]  refusal_code;
		logic [1:0]  shutdown_cause;
		logic        session_done;
		logic        low_battery;
		logic        over_voltage;
		logic        thermal_warning;
		logic [3:0]  daily_sessions;
	} result_t;

endpackage

### rtl/core/led_session_safety_controller.sv
// LED session safety controller: session timing, start checks, battery and
// thermal protection, result word register with one skid entry.
// Depends on lssc_pkg.
//
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------------
// in       | in_valid / in_stall  | operation, battery_mv, temperature_c
// out      | out_valid / out_stall| red_duty .. daily_sessions (11 fields)
// cfg      | cfg_write            | cfg_index, cfg_data (no read-back)
//
// One word per cycle while in_stall is low: the word is decoded straight from
// the input ports and the state and result registers update at the accepting
// edge. in_stall rises only when both the output register and the skid entry
// hold untaken words. arst_n clears all state, loads the register reset values
// and empties the output side; no clearing pass.
module led_session_safety_controller #(
	parameter int unsigned MAX_DAILY           = lssc_pkg::MAX_DAILY,
	parameter int unsigned MIN_GAP_MINUTES     = lssc_pkg::MIN_GAP_MINUTES,
	parameter int unsigned MAX_SESSION_SECONDS = lssc_pkg::MAX_SESSION_SECONDS,
	parameter int unsigned DAY_SECONDS         = lssc_pkg::DAY_SECONDS
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [13:0] battery_mv,
	input  logic signed [7:0] temperature_c,
	// result words
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red_duty,
	output logic [7:0]  nir_duty,
	output logic        session_on,
	output logic [15:0] elapsed_seconds,
	output logic [2:0]  refusal_code,
	output logic [1:0]  shutdown_cause,
	output logic        session_done,
	output logic        low_battery,
	output logic        over_voltage,
	output logic        thermal_warning,
	output logic [3:0]  daily_sessions,
	// configuration writes
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import lssc_pkg::*;

	// minimum rest after a normal end, in ticks
	localparam int unsigned GAP_SECONDS = MIN_GAP_MINUTES * 60;

	// configuration registers
	logic [2:0]  mode_q;
	logic [15:0] session_q;
	logic [7:0]  alternate_q;
	logic [13:0] bat_cutoff_q;
	logic [13:0] bat_low_q;
	logic [13:0] bat_over_q;
	logic signed [7:0] temp_warn_q;
	logic signed [7:0] temp_cut_q;

	// session state
	logic        active_q, active_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic        nir_phase_q, nir_phase_d;
	logic [7:0]  phase_timer_q, phase_timer_d;
	logic [7:0]  drive_q, drive_d;
	logic [3:0]  day_count_q, day_count_d;
	logic [16:0] day_timer_q, day_timer_d;
	logic [15:0] gap_timer_q, gap_timer_d;
	logic        ended_q, ended_d;
	logic [13:0] bat_level_q, bat_level_d;
	logic signed [7:0] temp_level_q, temp_level_d;
	logic        low_q, low_d;
	logic        over_q, over_d;
	logic        heat_q, heat_d;

	// output side: result register and skid entry
	result_t     res_d;
	result_t     out_q, skid_q;
	logic        out_v_q, skid_v_q;
	logic        in_acc, out_take;

	assign in_stall = skid_v_q;
	assign in_acc   = in_valid && !skid_v_q;
	assign out_take = out_v_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_BOTH;
			session_q    <= 16'd600;
			alternate_q  <= 8'd30;
			bat_cutoff_q <= 14'd6000;
			bat_low_q    <= 14'd6600;
			bat_over_q   <= 14'd8600;
			temp_warn_q  <= 8'sd40;
			temp_cut_q   <= 8'sd45;
		end else if (cfg_write) begin
			case (reg_idx_t'(cfg_index))
				REG_MODE:       mode_q       <= cfg_data[2:0];
				REG_SESSION:    session_q    <= cfg_data;
				REG_ALTERNATE:  alternate_q  <= cfg_data[7:0];
				REG_BAT_CUTOFF: bat_cutoff_q <= cfg_data[13:0];
				REG_BAT_LOW:    bat_low_q    <= cfg_data[13:0];
				REG_BAT_OVER:   bat_over_q   <= cfg_data[13:0];
				REG_TEMP_WARN:  temp_warn_q  <= cfg_data[7:0];
				REG_TEMP_CUT:   temp_cut_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// next state and result for the word on the input ports
	always_comb begin
		logic [8:0]        phase_next;
		logic signed [8:0] warn_low;
		logic [2:0]        refusal;
		logic [1:0]        cause;
		logic              done;
		logic [7:0]        red, nir;

		active_d      = active_q;
		elapsed_d     = elapsed_q;
		nir_phase_d   = nir_phase_q;
		phase_timer_d = phase_timer_q;
		drive_d       = drive_q;
		day_count_d   = day_count_q;
		day_timer_d   = day_timer_q;
		gap_timer_d   = gap_timer_q;
		ended_d       = ended_q;
		bat_level_d   = bat_level_q;
		temp_level_d  = temp_level_q;
		low_d         = low_q;
		over_d        = over_q;
		heat_d        = heat_q;
		refusal       = REFUSE_NONE;
		cause         = CAUSE_NONE;
		done          = 1'b0;
		red           = 8'd0;
		nir           = 8'd0;
		phase_next    = {1'b0, phase_timer_q} + 9'd1;
		warn_low      = 9'(temp_warn_q) - TEMP_HYST;

		case (operation)
			OP_TICK: begin
				if (day_timer_q < 17'(DAY_SECONDS))
					day_timer_d = day_timer_q + 17'd1;
				if (gap_timer_q != 16'hFFFF)
					gap_timer_d = gap_timer_q + 16'd1;
				if (active_q) begin
					if (elapsed_q != 16'hFFFF)
						elapsed_d = elapsed_q + 16'd1;
					if (mode_q == MODE_ALT) begin
						if (phase_next >= {1'b0, alternate_q}) begin
							nir_phase_d   = !nir_phase_q;
							phase_timer_d = 8'd0;
						end else begin
							phase_timer_d = phase_next[7:0];
						end
					end
					// timer end, or the hard session cap without the done pulse
					if (elapsed_d >= session_q) begin
						done        = 1'b1;
						active_d    = 1'b0;
						gap_timer_d = 16'd0;
						ended_d     = 1'b1;
					end else if (elapsed_d >= 16'(MAX_SESSION_SECONDS)) begin
						active_d    = 1'b0;
						gap_timer_d = 16'd0;
						ended_d     = 1'b1;
					end
				end
			end
			OP_START: begin
				if (!active_q) begin
					if (bat_level_q < bat_cutoff_q)
						refusal = REFUSE_LOW;
					else if (bat_level_q > bat_over_q)
						refusal = REFUSE_HIGH;
					else if (temp_level_q >= temp_cut_q)
						refusal = REFUSE_HOT;
					else begin
						// a full day since the window opened starts a new one
						if (day_timer_q >= 17'(DAY_SECONDS)) begin
							day_count_d = 4'd0;
							day_timer_d = 17'd0;
						end
						if ({28'd0, day_count_d} >= MAX_DAILY)
							refusal = REFUSE_DAILY;
						else if (ended_q && ({16'd0, gap_timer_q} < GAP_SECONDS))
							refusal = REFUSE_GAP;
						else begin
							active_d      = 1'b1;
							if (day_count_d != 4'hF)
								day_count_d = day_count_d + 4'd1;
							elapsed_d     = 16'd0;
							phase_timer_d = 8'd0;
							nir_phase_d   = 1'b0;
						end
					end
				end
			end
			OP_STOP: begin
				if (active_q) begin
					active_d    = 1'b0;
					gap_timer_d = 16'd0;
					ended_d     = 1'b1;
				end
			end
			OP_BATTERY: begin
				bat_level_d = battery_mv;
				if (battery_mv > bat_over_q) begin
					over_d   = 1'b1;
					cause    = CAUSE_OVER;
					active_d = 1'b0;
				end else begin
					over_d = 1'b0;
					if (battery_mv < bat_cutoff_q) begin
						cause    = CAUSE_UNDER;
						active_d = 1'b0;
					end else begin
						low_d = (battery_mv < bat_low_q);
					end
				end
			end
			OP_TEMP: begin
				temp_level_d = temperature_c;
				if (temperature_c >= temp_cut_q) begin
					cause    = CAUSE_THERMAL;
					active_d = 1'b0;
				end else if (temperature_c >= temp_warn_q && !heat_q) begin
					heat_d  = 1'b1;
					drive_d = DRIVE_HALF;
				end else if (9'(temperature_c) < warn_low) begin
					if (heat_q) begin
						heat_d  = 1'b0;
						drive_d = DRIVE_FULL;
					end
				end
			end
			default: ;
		endcase

		// duties from the updated state
		if (active_d) begin
			case (mode_q)
				MODE_RED:  red = drive_d;
				MODE_NIR:  nir = drive_d;
				MODE_BOTH: begin
					red = drive_d;
					nir = drive_d;
				end
				MODE_ALT: begin
					if (nir_phase_d) nir = drive_d;
					else red = drive_d;
				end
				default: ;
			endcase
		end

		res_d.red_duty        = red;
		res_d.nir_duty        = nir;
		res_d.session_on      = active_d;
		res_d.elapsed_seconds = elapsed_d;
		res_d.refusal_code    = refusal;
		res_d.shutdown_cause  = cause;
		res_d.session_done    = done;
		res_d.low_battery     = low_d;
		res_d.over_voltage    = over_d;
		res_d.thermal_warning = heat_d;
		res_d.daily_sessions  = day_count_d;
	end

	// state advances only on an accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q      <= 1'b0;
			elapsed_q     <= 16'd0;
			nir_phase_q   <= 1'b0;
			phase_timer_q <= 8'd0;
			drive_q       <= DRIVE_FULL;
			day_count_q   <= 4'd0;
			day_timer_q   <= 17'd0;
			gap_timer_q   <= 16'd0;
			ended_q       <= 1'b0;
			bat_level_q   <= 14'd0;
			temp_level_q  <= 8'sd0;
			low_q         <= 1'b0;
			over_q        <= 1'b0;
			heat_q        <= 1'b0;
		end else if (in_acc) begin
			active_q      <= active_d;
			elapsed_q     <= elapsed_d;
			nir_phase_q   <= nir_phase_d;
			phase_timer_q <= phase_timer_d;
			drive_q       <= drive_d;
			day_count_q   <= day_count_d;
			day_timer_q   <= day_timer_d;
			gap_timer_q   <= gap_timer_d;
			ended_q       <= ended_d;
			bat_level_q   <= bat_level_d;
			temp_level_q  <= temp_level_d;
			low_q         <= low_d;
			over_q        <= over_d;
			heat_q        <= heat_d;
		end
	end

	// output valid flags: skid drains into the output register first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_take)
				skid_v_q <= 1'b0;
		end else if (in_acc) begin
			if (out_v_q && !out_take)
				skid_v_q <= 1'b1;
			else
				out_v_q <= 1'b1;
		end else if (out_take) begin
			out_v_q <= 1'b0;
		end
	end

	// result payload registers
	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_take)
				out_q <= skid_q;
		end else if (in_acc) begin
			if (out_v_q && !out_take)
				skid_q <= res_d;
			else
				out_q <= res_d;
		end
	end

	assign out_valid       = out_v_q;
	assign red_duty        = out_q.red_duty;
	assign nir_duty        = out_q.nir_duty;
	assign session_on      = out_q.session_on;
	assign elapsed_seconds = out_q.elapsed_seconds;
	assign refusal_code    = out_q.refusal_code;
	assign shutdown_cause  = out_q.shutdown_cause;
	assign session_done    = out_q.session_done;
	assign low_battery     = out_q.low_battery;
	assign over_voltage    = out_q.over_voltage;
	assign thermal_warning = out_q.thermal_warning;
	assign daily_sessions  = out_q.daily_sessions;

endmodule
